### design/i6t_pkg.sv
// ----------------------------------------------------------------------------
// i6t_pkg
// Shared types, constants and helpers for the IPv6 address text formatter.
// ----------------------------------------------------------------------------
package i6t_pkg;

   localparam int WordCount = 8;
   localparam int MinRun    = 2;
   localparam int WordIdxW  = $clog2(WordCount);
   localparam int RunW      = $clog2(WordCount + 1);

   localparam logic [6:0] CharColon = 7'h3a;
   localparam logic [6:0] CharZero  = 7'h30;
   localparam logic [6:0] CharAlpha = 7'h57;

   typedef struct packed {
      logic       zero;
      logic [2:0] ndig;
   } lane_type;

   typedef struct packed {
      logic [WordCount-1:0][15:0] words;
      logic [WordCount-1:0][2:0]  ndig;
      logic [WordCount-1:0]       skip;
      logic [WordCount-1:0]       colon;
      logic                       tail;
   } job_type;

   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      logic [6:0] base;
      base = (nib < 4'd10) ? CharZero : CharAlpha;
      return base + {3'b000, nib};
   endfunction

endpackage

### design/ipv6_address_to_text_core.sv
// ----------------------------------------------------------------------------
// ipv6_address_to_text_core
// Formats a 128-bit IPv6 address as canonical lowercase text, one character
// per output transfer.
// ----------------------------------------------------------------------------
// The request channel takes one address per transfer: the upper half in the
// low 64 bits of req_tdata, the lower half above it. Eight lanes examine the
// eight 16-bit words in parallel and a merge stage picks the first longest
// zero run of two or more words for the "::" shortening.
// The response channel returns the text as ASCII, one character per
// transfer, with rsp_tlast on the final character of each address.
// An address gives between 2 and 39 characters on the response channel.
// When the block is empty the first character passes through the pending
// slot, the active register and the output register. A second address is
// buffered while the current one streams, so consecutive texts follow
// without gaps.
// When rsp_tready is low the output register holds its character and
// emission pauses; req_tready drops once the buffer slot is full.
// Synchronous reset discards any buffered or partly sent address.
// ----------------------------------------------------------------------------
module ipv6_address_to_text_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // addr_high [63:0], addr_low [127:64]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,   // char_code [6:0], zero [7]
   output logic         rsp_tlast
);
   import i6t_pkg::*;

   logic [WordCount-1:0][15:0] words;
   lane_type [WordCount-1:0]   lanes;
   job_type                    job;
   logic [6:0]                 char_code;

   always_comb begin
      for (int i = 0; i < WordCount / 2; i++) begin
         words[i]                 = req_tdata[63 - 16 * i -: 16];
         words[i + WordCount / 2] = req_tdata[127 - 16 * i -: 16];
      end
   end

   for (genvar g = 0; g < WordCount; g++) begin : g_lane
      i6t_lane u_lane (
         .word (words[g]),
         .info (lanes[g])
      );
   end

   i6t_merge u_merge (
      .words (words),
      .lanes (lanes),
      .job   (job)
   );

   i6t_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .job_valid (req_tvalid),
      .job_ready (req_tready),
      .job       (job),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (char_code),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, char_code};

endmodule

### design/i6t_lane.sv
// ----------------------------------------------------------------------------
// i6t_lane
// Per-word lane: flags a zero word and counts its significant hex digits.
// ----------------------------------------------------------------------------
module i6t_lane (
   input  logic [15:0]      word,
   output i6t_pkg::lane_type info
);
   import i6t_pkg::*;

   always_comb begin
      info.zero = (word == 16'h0000);
      priority if (word[15:12] != 4'h0) begin
         info.ndig = 3'd4;
      end else if (word[11:8] != 4'h0) begin
         info.ndig = 3'd3;
      end else if (word[7:4] != 4'h0) begin
         info.ndig = 3'd2;
      end else begin
         info.ndig = 3'd1;
      end
   end

endmodule

### design/i6t_merge.sv
// ----------------------------------------------------------------------------
// i6t_merge
// Combines the lane results: finds the first longest zero run and marks
// which words print, which carry a leading colon and whether a colon trails.
// ----------------------------------------------------------------------------
module i6t_merge (
   input  logic [i6t_pkg::WordCount-1:0][15:0] words,
   input  i6t_pkg::lane_type [i6t_pkg::WordCount-1:0] lanes,
   output i6t_pkg::job_type job
);
   import i6t_pkg::*;

   logic [RunW-1:0] run_pos;
   logic [RunW-1:0] run_len;
   logic [RunW-1:0] best_pos;
   logic [RunW-1:0] best_len;
   logic [RunW-1:0] run_end;

   always_comb begin
      run_pos  = '0;
      best_pos = '0;
      best_len = '0;
      for (int i = 0; i < WordCount; i++) begin
         if (!lanes[i].zero) begin
            run_len = RunW'(i) - run_pos;
            if (run_len > best_len) begin
               best_pos = run_pos;
               best_len = run_len;
            end
            run_pos = RunW'(i + 1);
         end
      end
      run_len = RunW'(WordCount) - run_pos;
      if (run_len > best_len) begin
         best_pos = run_pos;
         best_len = run_len;
      end
      if (best_len < RunW'(MinRun)) begin
         best_pos = '0;
         best_len = '0;
      end
      run_end = best_pos + best_len;

      job.words = words;
      for (int i = 0; i < WordCount; i++) begin
         job.ndig[i]  = lanes[i].ndig;
         job.skip[i]  = (best_len != '0) && (RunW'(i) >= best_pos) && (RunW'(i) < run_end);
         job.colon[i] = job.skip[i] ? (RunW'(i) == best_pos) : (i != 0);
      end
      job.tail = (best_len != '0) && (run_end == RunW'(WordCount));
   end

endmodule

### design/i6t_serial.sv
// ----------------------------------------------------------------------------
// i6t_serial
// Holds one pending and one active address and streams the active text out
// one character per transfer through an output register.
// ----------------------------------------------------------------------------
module i6t_serial (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  i6t_pkg::job_type job,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [6:0]       out_char,
   output logic             out_last
);
   import i6t_pkg::*;

   job_type             pend_ff, pend_in;
   logic                pend_v_ff, pend_v_in;
   job_type             cur_ff, cur_in;
   logic                act_ff, act_in;
   logic [WordIdxW-1:0] word_ff, word_in;
   logic [2:0]          pos_ff, pos_in;
   logic                tail_ff, tail_in;
   logic                rsp_v_ff, rsp_v_in;
   logic [6:0]          char_ff, char_in;
   logic                last_ff, last_in;

   logic                adv, step, load, accept;
   logic                word_end, found;
   logic [WordIdxW-1:0] next_word;
   logic [1:0]          dsel;
   logic [15:0]         cur_word;
   logic [3:0]          nib;
   logic [6:0]          cur_char;
   logic                cur_last;

   assign job_ready = !pend_v_ff;
   assign accept    = job_valid && !pend_v_ff;

   always_comb begin
      cur_word  = cur_ff.words[word_ff];
      dsel      = 2'(cur_ff.ndig[word_ff] - pos_ff);
      nib       = 4'(cur_word >> {dsel, 2'b00});
      word_end  = cur_ff.skip[word_ff] ? 1'b1 : (pos_ff == cur_ff.ndig[word_ff]);
      found     = 1'b0;
      next_word = '0;
      for (int j = WordCount - 1; j >= 0; j--) begin
         if ((WordIdxW'(j) > word_ff) && (cur_ff.colon[j] || !cur_ff.skip[j])) begin
            found     = 1'b1;
            next_word = WordIdxW'(j);
         end
      end
      if (tail_ff) begin
         cur_char = CharColon;
         cur_last = 1'b1;
      end else begin
         cur_char = (pos_ff == 3'd0) ? CharColon : hex_char(nib);
         cur_last = word_end && !found && !cur_ff.tail;
      end

      adv  = !rsp_v_ff || out_ready;
      step = act_ff && adv;
      load = pend_v_ff && (!act_ff || (step && cur_last));

      pend_in   = accept ? job : pend_ff;
      pend_v_in = accept ? 1'b1 : (load ? 1'b0 : pend_v_ff);

      cur_in  = cur_ff;
      act_in  = act_ff;
      word_in = word_ff;
      pos_in  = pos_ff;
      tail_in = tail_ff;
      if (load) begin
         cur_in  = pend_ff;
         act_in  = 1'b1;
         word_in = '0;
         pos_in  = pend_ff.colon[0] ? 3'd0 : 3'd1;
         tail_in = 1'b0;
      end else if (step) begin
         if (cur_last) begin
            act_in = 1'b0;
         end else if (word_end) begin
            if (found) begin
               word_in = next_word;
               pos_in  = cur_ff.colon[next_word] ? 3'd0 : 3'd1;
            end else begin
               tail_in = 1'b1;
            end
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end

      rsp_v_in = step || (rsp_v_ff && !out_ready);
      char_in  = step ? cur_char : char_ff;
      last_in  = step ? cur_last : last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
         act_ff    <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         pend_v_ff <= pend_v_in;
         act_ff    <= act_in;
         rsp_v_ff  <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      cur_ff  <= cur_in;
      word_ff <= word_in;
      pos_ff  <= pos_in;
      tail_ff <= tail_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign out_valid = rsp_v_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;

endmodule
